// ===== rtl/ole_pkg.sv =====
// package for ordered list engine: opcodes, status codes, sizes, fsm states
// no dependencies
`timescale 1ns / 1ps
package ole_pkg;
    localparam int CAPACITY = 32;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MAX_RESULTS = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_VALUE = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic            we;
        logic [AW-1:0]   waddr;
        logic [31:0]     wdata;
        logic [AW-1:0]   raddr;
    } t_mem_req;
endpackage

// ===== rtl/ole_ram.sv =====
// single-port-write, single-port-read entry store with a registered read port
// uses ole_pkg
`timescale 1ns / 1ps
module ole_ram (
    input  logic              i_clk,
    input  ole_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    logic [31:0] r_mem [ole_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// ===== rtl/ordered_list_engine_core.sv =====
// ordered list engine top level: sequencer around the entry store
// uses ole_pkg and ole_ram
// search/dump results leave at most one item per cycle
// takes one input item at a time; the next is accepted only after the last result is taken
// shifts walk the store one entry per cycle through its read port; scans do so while the output is free
// reset empties the list at once; the store contents need no clearing
`timescale 1ns / 1ps
module ordered_list_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [34:3] operand_value, [66:35] anchor_value, zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] entry_value, [38:34] entry_position, zero fill
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int AW = ole_pkg::AW;
    localparam int CW = ole_pkg::CW;
    localparam int MAX_RES = ole_pkg::MAX_RESULTS;

    ole_pkg::t_state   r_state, n_state;
    ole_pkg::t_opcode  r_op, n_op;
    logic [31:0]       r_val, n_val, r_anc, n_anc;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_tgt, n_tgt;
    logic              r_rd, n_rd;
    logic [AW-1:0]     r_rdpos, n_rdpos;
    logic [CW-1:0]     r_nres, n_nres;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ost, n_ost;
    logic [31:0]       r_oval, n_oval;
    logic [4:0]        r_opos, n_opos;
    logic              r_olast, n_olast;
    logic              r_pend, n_pend;
    logic [1:0]        r_pst, n_pst;
    logic [31:0]       r_pval, n_pval;
    logic [4:0]        r_ppos, n_ppos;
    ole_pkg::t_mem_req w_req;
    logic [31:0]       w_rdata;
    logic              w_in_acc, w_out_free;

    ole_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    assign s_axis_tready = (r_state == ole_pkg::S_IDLE) && !r_ovalid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {1'b0, r_opos, r_oval, r_ost};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ole_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rd     <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_rd     <= n_rd;
            r_pend   <= n_pend;
        end
        r_op <= n_op; r_val <= n_val; r_anc <= n_anc; r_idx <= n_idx;
        r_tgt <= n_tgt; r_rdpos <= n_rdpos; r_nres <= n_nres;
        r_ost <= n_ost; r_oval <= n_oval; r_opos <= n_opos; r_olast <= n_olast;
        r_pst <= n_pst; r_pval <= n_pval; r_ppos <= n_ppos;
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_val = r_val; n_anc = r_anc;
        n_count = r_count; n_idx = r_idx; n_tgt = r_tgt; n_rd = 1'b0;
        n_rdpos = r_rdpos; n_nres = r_nres;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ost = r_ost; n_oval = r_oval; n_opos = r_opos; n_olast = r_olast;
        n_pend = r_pend; n_pst = r_pst; n_pval = r_pval; n_ppos = r_ppos;
        w_req = '{we: 1'b0, waddr: '0, wdata: r_val, raddr: r_idx[AW-1:0]};
        case (r_state)
            ole_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_op  = ole_pkg::t_opcode'(s_axis_tdata[2:0]);
                    n_val = s_axis_tdata[34:3];
                    n_anc = s_axis_tdata[66:35];
                    n_idx = '0;
                    n_nres = '0;
                    n_ovalid = 1'b1; n_ost = ole_pkg::ST_OK; n_oval = '0;
                    n_opos = '0; n_olast = 1'b1;
                    case (ole_pkg::t_opcode'(s_axis_tdata[2:0]))
                        ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK,
                        ole_pkg::OP_INS_AFTER: begin
                            if (r_count >= CW'(ole_pkg::CAPACITY)) begin
                                n_ost = ole_pkg::ST_FULL;
                            end else if (s_axis_tdata[2:0] == ole_pkg::OP_INS_FRONT) begin
                                n_ovalid = 1'b0; n_tgt = '0;
                                n_idx = r_count; n_state = ole_pkg::S_SHIFT_UP;
                            end else if (s_axis_tdata[2:0] == ole_pkg::OP_INS_BACK
                                         || r_count == '0) begin
                                n_ovalid = 1'b0; n_tgt = r_count;
                                n_idx = r_count; n_state = ole_pkg::S_SHIFT_UP;
                            end else begin
                                n_ovalid = 1'b0; n_state = ole_pkg::S_FIND;
                            end
                        end
                        ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_BACK,
                        ole_pkg::OP_DEL_VALUE: begin
                            if (r_count == '0) begin
                                n_ost = ole_pkg::ST_EMPTY;
                            end else if (s_axis_tdata[2:0] == ole_pkg::OP_DEL_BACK) begin
                                n_count = r_count - 1'b1;
                            end else if (s_axis_tdata[2:0] == ole_pkg::OP_DEL_FRONT) begin
                                n_ovalid = 1'b0; n_idx = '0;
                                n_state = ole_pkg::S_SHIFT_DN;
                            end else begin
                                n_ovalid = 1'b0; n_state = ole_pkg::S_FIND;
                            end
                        end
                        ole_pkg::OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_ost = ole_pkg::ST_NOT_FOUND;
                            end else begin
                                n_ovalid = 1'b0; n_pend = 1'b0;
                                n_state = ole_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_ost = ole_pkg::ST_EMPTY;
                            end else begin
                                n_ovalid = 1'b0; n_pend = 1'b0;
                                n_state = ole_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end
            ole_pkg::S_FIND: begin
                // issue reads in order; check each read's data in the cycle after it is issued
                if (r_rd && w_rdata == ((r_op == ole_pkg::OP_INS_AFTER) ? r_anc : r_val)) begin
                    if (r_op == ole_pkg::OP_INS_AFTER) begin
                        n_tgt = CW'(r_rdpos) + 1'b1; n_idx = r_count;
                        n_state = ole_pkg::S_SHIFT_UP;
                    end else begin
                        n_idx = CW'(r_rdpos); n_state = ole_pkg::S_SHIFT_DN;
                    end
                end else if (r_idx < r_count) begin
                    w_req.raddr = r_idx[AW-1:0];
                    n_rd = 1'b1; n_rdpos = r_idx[AW-1:0]; n_idx = r_idx + 1'b1;
                end else if (!r_rd) begin
                    n_ovalid = 1'b1; n_ost = ole_pkg::ST_NOT_FOUND; n_oval = '0;
                    n_opos = '0; n_olast = 1'b1; n_state = ole_pkg::S_IDLE;
                end
            end
            ole_pkg::S_SHIFT_UP: begin
                // r_idx is the slot being written; read idx-1, write next cycle
                if (r_rd) begin
                    w_req.we = 1'b1; w_req.waddr = r_idx[AW-1:0]; w_req.wdata = w_rdata;
                end
                if (r_rd || r_idx == r_tgt) begin
                    if (r_rd && r_idx - 1'b1 == r_tgt) begin
                        n_idx = r_idx - 1'b1;
                    end else if (!r_rd && r_idx == r_tgt) begin
                        w_req.we = 1'b1; w_req.waddr = r_idx[AW-1:0];
                        w_req.wdata = r_val;
                        n_count = r_count + 1'b1; n_ovalid = 1'b1;
                        n_ost = ole_pkg::ST_OK; n_oval = '0; n_opos = '0;
                        n_olast = 1'b1; n_state = ole_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                        w_req.raddr = AW'(r_idx - 2'd2); n_rd = 1'b1;
                    end
                end else begin
                    w_req.raddr = AW'(r_idx - 1'b1); n_rd = 1'b1;
                end
            end
            ole_pkg::S_SHIFT_DN: begin
                // r_idx is the slot being written from idx+1
                if (r_rd) begin
                    w_req.we = 1'b1; w_req.waddr = r_idx[AW-1:0]; w_req.wdata = w_rdata;
                    n_idx = r_idx + 1'b1;
                end
                if ((r_rd ? r_idx + 2'd2 : r_idx + 1'b1) < r_count) begin
                    w_req.raddr = AW'(r_rd ? r_idx + 2'd2 : r_idx + 1'b1);
                    n_rd = 1'b1;
                end else begin
                    n_count = r_count - 1'b1; n_ovalid = 1'b1;
                    n_ost = ole_pkg::ST_OK; n_oval = '0; n_opos = '0;
                    n_olast = 1'b1; n_state = ole_pkg::S_EMIT;
                end
            end
            ole_pkg::S_SCAN: begin
                // one read per cycle while the output is free; a hit waits in r_p* until the next hit or end
                if (w_out_free) begin
                    if (r_rd && (r_op == ole_pkg::OP_DUMP || w_rdata == r_val)
                        && r_nres < CW'(MAX_RES)) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1; n_ost = r_pst; n_oval = r_pval;
                            n_opos = r_ppos; n_olast = 1'b0;
                        end
                        n_pend = 1'b1; n_pst = ole_pkg::ST_OK; n_pval = w_rdata;
                        n_ppos = 5'(r_rdpos); n_nres = r_nres + 1'b1;
                    end
                    if (r_idx < r_count) begin
                        w_req.raddr = r_idx[AW-1:0]; n_rd = 1'b1;
                        n_rdpos = r_idx[AW-1:0]; n_idx = r_idx + 1'b1;
                    end else if (!r_rd) begin
                        n_ovalid = 1'b1; n_olast = 1'b1; n_state = ole_pkg::S_IDLE;
                        if (r_pend) begin
                            n_ost = r_pst; n_oval = r_pval; n_opos = r_ppos;
                        end else begin
                            n_ost = ole_pkg::ST_NOT_FOUND; n_oval = '0; n_opos = '0;
                        end
                    end
                end else begin
                    n_rd = r_rd;
                    if (r_rd) begin
                        w_req.raddr = r_rdpos;
                    end
                end
            end
            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ole_pkg::CAPACITY)) else $error("count above capacity");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ole_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(m_axis_tdata)))
        else $error("output dropped");
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.we |-> (CW'(w_req.waddr) <= r_count)) else $error("write past end");
endmodule

// ===== sim/ole_checker.sv =====
// ordered list engine checker: watches both stream channels, predicts results
// depends on ole_pkg; instantiated by tb beside the block
`timescale 1ns / 1ps
module ole_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    typedef struct packed {
        ole_pkg::t_status status;
        logic [31:0]      value;
        logic [4:0]       position;
        logic             last;
    } t_report;

    logic [31:0] list_q[$];
    t_report     report_q[$];

    function automatic int find_value(logic [31:0] v);
        for (int i = 0; i < list_q.size(); i++)
            if (list_q[i] == v) return i;
        return -1;
    endfunction

    task automatic push_report(ole_pkg::t_status st, logic [31:0] v, int pos, logic last);
        t_report r;
        r.status = st;
        r.value = v;
        r.position = pos[4:0];
        r.last = last;
        report_q.push_back(r);
    endtask

    task automatic apply_command(logic [71:0] d);
        ole_pkg::t_opcode op;
        logic [31:0]      val;
        logic [31:0]      anc;
        int               p;
        int               k;
        op = ole_pkg::t_opcode'(d[2:0]);
        val = d[34:3];
        anc = d[66:35];
        k = 0;
        case (op)
            ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK, ole_pkg::OP_INS_AFTER: begin
                if (list_q.size() >= ole_pkg::CAPACITY) begin
                    push_report(ole_pkg::ST_FULL, 0, 0, 1);
                end else if (op == ole_pkg::OP_INS_FRONT) begin
                    list_q.push_front(val);
                    push_report(ole_pkg::ST_OK, 0, 0, 1);
                end else if (op == ole_pkg::OP_INS_BACK || list_q.size() == 0) begin
                    list_q.push_back(val);
                    push_report(ole_pkg::ST_OK, 0, 0, 1);
                end else begin
                    p = find_value(anc);
                    if (p < 0) begin
                        push_report(ole_pkg::ST_NOT_FOUND, 0, 0, 1);
                    end else begin
                        list_q.insert(p + 1, val);
                        push_report(ole_pkg::ST_OK, 0, 0, 1);
                    end
                end
            end
            ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_BACK, ole_pkg::OP_DEL_VALUE: begin
                if (list_q.size() == 0) begin
                    push_report(ole_pkg::ST_EMPTY, 0, 0, 1);
                end else begin
                    p = (op == ole_pkg::OP_DEL_FRONT) ? 0 :
                        (op == ole_pkg::OP_DEL_BACK) ? list_q.size() - 1 : find_value(val);
                    if (p < 0) begin
                        push_report(ole_pkg::ST_NOT_FOUND, 0, 0, 1);
                    end else begin
                        list_q.delete(p);
                        push_report(ole_pkg::ST_OK, 0, 0, 1);
                    end
                end
            end
            ole_pkg::OP_SEARCH: begin
                for (int i = 0; i < list_q.size() && k < ole_pkg::MAX_RESULTS; i++)
                    if (list_q[i] == val) begin
                        push_report(ole_pkg::ST_OK, val, i, 0);
                        k++;
                    end
                if (k == 0) push_report(ole_pkg::ST_NOT_FOUND, 0, 0, 1);
                else report_q[report_q.size() - 1].last = 1;
            end
            default: begin
                if (list_q.size() == 0) begin
                    push_report(ole_pkg::ST_EMPTY, 0, 0, 1);
                end else begin
                    for (int i = 0; i < list_q.size() && k < ole_pkg::MAX_RESULTS; i++) begin
                        push_report(ole_pkg::ST_OK, list_q[i], i, 0);
                        k++;
                    end
                    report_q[report_q.size() - 1].last = 1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_report e;
        if (!i_rst_n) begin
            list_q.delete();
            report_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_pending <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                o_result_count <= o_result_count + 1;
                if (report_q.size() == 0) begin
                    $error("unexpected item %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = report_q.pop_front();
                    if (m_axis_tdata[1:0] !== e.status ||
                        m_axis_tdata[33:2] !== e.value ||
                        m_axis_tdata[38:34] !== e.position ||
                        m_axis_tlast !== e.last) begin
                        if (m_axis_tdata[1:0] !== e.status)
                            $error("status exp %0d got %0d", e.status, m_axis_tdata[1:0]);
                        if (m_axis_tdata[33:2] !== e.value)
                            $error("entry_value exp %h got %h", e.value,
                                   m_axis_tdata[33:2]);
                        if (m_axis_tdata[38:34] !== e.position)
                            $error("entry_position exp %0d got %0d", e.position,
                                   m_axis_tdata[38:34]);
                        if (m_axis_tlast !== e.last)
                            $error("is_last exp %0d got %0d", e.last, m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) apply_command(s_axis_tdata);
            o_pending <= report_q.size();
        end
    end
endmodule

// ===== sim/tb.sv =====
// ordered list engine testbench top: clock, reset, stimulus and verdict
// depends on ole_pkg, ordered_list_engine_core and ole_checker
`timescale 1ns / 1ps
module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          result_count;
    int          cycle_count = 0;
    int          sent_count;
    bit          hold_off;
    bit          calm;

    logic [31:0] pool[8];

    ordered_list_engine_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    ole_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off on request, none when calm
    initial begin
        int n;
        bit held;
        held = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                held = 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(ole_pkg::t_opcode op, logic [31:0] v, logic [31:0] a);
        s_axis_tdata <= {5'd0, a, v, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (ole_pkg::CAPACITY + 8) @(negedge i_clk);
    endtask

    initial begin
        int r;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sent_count = 0;
        hold_off = 0;
        calm = 0;
        for (int i = 0; i < 8; i++) pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'hffff_ffff;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list cases, extremes, every opcode
        send_item(ole_pkg::OP_DUMP, 0, 0);
        send_item(ole_pkg::OP_SEARCH, 5, 0);
        send_item(ole_pkg::OP_DEL_FRONT, 0, 0);
        send_item(ole_pkg::OP_DEL_BACK, 0, 0);
        send_item(ole_pkg::OP_DEL_VALUE, 5, 0);
        send_item(ole_pkg::OP_INS_AFTER, 32'h7fff_ffff, 32'h1234);
        send_item(ole_pkg::OP_INS_FRONT, 32'h8000_0000, 0);
        send_item(ole_pkg::OP_INS_BACK, 32'hffff_ffff, 0);
        send_item(ole_pkg::OP_INS_AFTER, 32'h0, 32'h5555_5555);
        send_item(ole_pkg::OP_INS_AFTER, 32'haaaa_aaaa, 32'h8000_0000);
        send_item(ole_pkg::OP_INS_BACK, 32'h8000_0000, 0);
        send_item(ole_pkg::OP_SEARCH, 32'h8000_0000, 0);
        send_item(ole_pkg::OP_DUMP, 0, 0);
        send_item(ole_pkg::OP_DEL_VALUE, 32'h1, 0);
        send_item(ole_pkg::OP_DEL_VALUE, 32'h8000_0000, 0);
        send_item(ole_pkg::OP_DEL_BACK, 0, 0);
        send_item(ole_pkg::OP_DEL_FRONT, 0, 0);
        // fill to capacity, then full refusals, a search and a dump
        for (int i = 0; i < ole_pkg::CAPACITY; i++)
            send_item(ole_pkg::OP_INS_BACK, pool[i % 8], 0);
        send_item(ole_pkg::OP_INS_FRONT, 1, 0);
        send_item(ole_pkg::OP_INS_AFTER, 1, 32'h5a5a_5a5a);
        send_item(ole_pkg::OP_SEARCH, pool[2], 0);
        send_item(ole_pkg::OP_DUMP, 0, 0);

        // sender pauses until everything is back, then receiver holds off
        wait_drained();
        hold_off = 1;
        for (int i = 0; i < 8; i++) send_item(ole_pkg::OP_DUMP, 0, 0);

        // random: mostly small-pool values so matches and anchors hit
        for (int n = 0; n < 380; n++) begin
            if (n == 330) calm = 1;
            r = $urandom_range(0, 19);
            if (r < 9)
                send_item(ole_pkg::t_opcode'($urandom_range(0, 2)), pick_value(),
                          pick_value());
            else if (r < 16)
                send_item(ole_pkg::t_opcode'($urandom_range(3, 5)), pick_value(), $urandom);
            else
                send_item(ole_pkg::t_opcode'($urandom_range(6, 7)), pick_value(), $urandom);
        end

        s_axis_tvalid <= 1'b0;
        r = 0;
        while (pending != 0 && r < 20000) begin
            @(negedge i_clk);
            r++;
        end
        repeat (ole_pkg::CAPACITY + 8) @(negedge i_clk);
        $display("tb: %0d items sent, %0d results checked", sent_count, result_count);
        $display("tb: empty, full, anchor and search/dump cases plus random mixes");
        if (fail_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ordered_list_engine_core.sv
sim/ole_checker.sv
sim/tb.sv
